>>> hdl/mvbbo_pkg.sv
package mvbbo_pkg;

  localparam int unsigned NumVenuesDefault = 16;
  localparam int unsigned VenueW = 4;
  localparam int unsigned ValW = 63;
  localparam int unsigned AgeW = 40;
  localparam int unsigned FreshW = 5;
  localparam logic [AgeW-1:0] MaxAgeReset = 40'd1000000000;

  typedef enum logic [2:0] {
    ModeUpdate = 3'd0,
    ModeStale  = 3'd1,
    ModeRemove = 3'd2,
    ModeCheck  = 3'd3,
    ModeClear  = 3'd4
  } mode_e;

  typedef struct packed {
    logic [2:0]        mode;
    logic [VenueW-1:0] venue;
    logic [ValW-1:0]   bid_px_in;
    logic [ValW-1:0]   bid_qty_in;
    logic [ValW-1:0]   ask_px_in;
    logic [ValW-1:0]   ask_qty_in;
    logic [ValW-1:0]   time_ns;
  } in_item_t;

  typedef struct packed {
    logic [ValW-1:0]   top_bid_px;
    logic [ValW-1:0]   top_bid_qty;
    logic [VenueW-1:0] top_bid_ven;
    logic [ValW-1:0]   top_ask_px;
    logic [ValW-1:0]   top_ask_qty;
    logic [VenueW-1:0] top_ask_ven;
    logic [63:0]       spread;
    logic [ValW-1:0]   mid_px;
    logic [FreshW-1:0] fresh_venues;
  } out_item_t;

  // Entry as it travels round the ring of cells.
  typedef struct packed {
    logic            present;
    logic            stale;
    logic [ValW-1:0] bid_px;
    logic [ValW-1:0] bid_qty;
    logic [ValW-1:0] ask_px;
    logic [ValW-1:0] ask_qty;
    logic [ValW-1:0] last_update;
  } entry_t;

  // Command broadcast to the head cell during one pass.
  typedef struct packed {
    logic            shift;
    logic            apply;
    logic [2:0]      mode;
    logic            hit;
    logic [ValW-1:0] bid_px;
    logic [ValW-1:0] bid_qty;
    logic [ValW-1:0] ask_px;
    logic [ValW-1:0] ask_qty;
    logic [ValW-1:0] now;
    logic [AgeW-1:0] max_age;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StFinish,
    StOut
  } state_e;

endpackage

>>> hdl/multi_venue_best_bid_offer.sv
// Channel | Signals                               | Direction
// input   | in_valid_i, in_ready_o, in_item_i     | in
// result  | out_valid_o, out_ready_i, out_item_o | out
// config  | cfg_valid_i, cfg_ready_o, cfg_data_i  | in
// For each item the entries circulate once round the ring of cells, one per cycle;
// then the finish state does the last compare, the result is valid in the output
// state, and the block returns to idle before the next item is taken.
// The result is held in the best-of registers until taken.
// Reset is asynchronous; all venues are absent and the maximum age is 1e9 ns afterwards.
// A stalled result holds the block; the next item is taken once the result leaves.
module multi_venue_best_bid_offer #(
  parameter int unsigned NUM_VENUES = mvbbo_pkg::NumVenuesDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  mvbbo_pkg::in_item_t      in_item_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output mvbbo_pkg::out_item_t     out_item_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [mvbbo_pkg::AgeW-1:0] cfg_data_i
);

  localparam int unsigned IdxW = $clog2(NUM_VENUES);
  localparam int unsigned CntW = $clog2(NUM_VENUES + 1);
  localparam int unsigned VW = mvbbo_pkg::ValW;

  mvbbo_pkg::state_e state_q, state_d;
  mvbbo_pkg::in_item_t item_q;
  logic [mvbbo_pkg::AgeW-1:0] max_age_q;
  logic [IdxW-1:0] idx_q;
  mvbbo_pkg::entry_t ring [NUM_VENUES];
  mvbbo_pkg::cell_ctrl_t ctrl_head, ctrl_rest;

  logic [VW-1:0] bp_q, bq_q, ap_q, aq_q;
  logic [IdxW-1:0] bv_q, av_q;
  logic ask_found_q;
  logic [CntW-1:0] fresh_q;
  logic [63:0] spread_w;
  logic [VW:0] sum_w;
  logic [4:0] fresh_sat;
  logic [31:0] venue_ext;
  logic accept, scanning, last;
  mvbbo_pkg::entry_t cur;

  assign in_ready_o = (state_q == mvbbo_pkg::StIdle);
  assign cfg_ready_o = 1'b1;
  assign accept = in_valid_i && in_ready_o;
  assign scanning = (state_q == mvbbo_pkg::StScan);
  assign last = (idx_q == IdxW'(NUM_VENUES - 1));
  assign venue_ext = 32'(item_q.venue);

  // The tail cell holds the venue at idx_q; it re-enters at the head.
  always_comb begin
    ctrl_head.shift = scanning;
    ctrl_head.apply = 1'b1;
    ctrl_head.mode = item_q.mode;
    ctrl_head.hit = (venue_ext < NUM_VENUES) && (venue_ext == 32'(idx_q));
    ctrl_head.bid_px = item_q.bid_px_in;
    ctrl_head.bid_qty = item_q.bid_qty_in;
    ctrl_head.ask_px = item_q.ask_px_in;
    ctrl_head.ask_qty = item_q.ask_qty_in;
    ctrl_head.now = item_q.time_ns;
    ctrl_head.max_age = max_age_q;
    ctrl_rest = ctrl_head;
    ctrl_rest.apply = 1'b0;
  end

  for (genvar g = 0; g < NUM_VENUES; g++) begin : g_cell
    mvbbo_cell u_cell (
      .clk_i,
      .rst_ni,
      .ctrl_i  (g == 0 ? ctrl_head : ctrl_rest),
      .entry_i (ring[(g + NUM_VENUES - 1) % NUM_VENUES]),
      .entry_o (ring[g])
    );
  end

  // Entry leaving the head cell after the event: the one compared this cycle.
  assign cur = ring[0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      mvbbo_pkg::StIdle: if (accept) state_d = mvbbo_pkg::StScan;
      mvbbo_pkg::StScan: if (last) state_d = mvbbo_pkg::StFinish;
      mvbbo_pkg::StFinish: state_d = mvbbo_pkg::StOut;
      mvbbo_pkg::StOut: if (out_ready_i) state_d = mvbbo_pkg::StIdle;
      default: state_d = mvbbo_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mvbbo_pkg::StIdle;
      max_age_q <= mvbbo_pkg::MaxAgeReset;
      idx_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) max_age_q <= cfg_data_i;
      if (accept) idx_q <= '0;
      else if (scanning) idx_q <= idx_q + IdxW'(1);
    end
  end

  // Compare runs in the cycle after the ring shift: the head cell registers the updated entry.
  logic cmp_q;
  logic [IdxW-1:0] cidx_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cmp_q <= 1'b0;
    else cmp_q <= scanning;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
      bp_q <= '0; bq_q <= '0; bv_q <= '0;
      ap_q <= '0; aq_q <= '0; av_q <= '0;
      ask_found_q <= 1'b0;
      fresh_q <= '0;
    end else if (cmp_q && cur.present && !cur.stale) begin
      fresh_q <= fresh_q + CntW'(1);
      if (cur.bid_px > bp_q && cur.bid_qty != '0) begin
        bp_q <= cur.bid_px; bq_q <= cur.bid_qty; bv_q <= cidx_q;
      end
      if (cur.ask_qty != '0 && (!ask_found_q || cur.ask_px < ap_q)) begin
        ask_found_q <= 1'b1;
        ap_q <= cur.ask_px; aq_q <= cur.ask_qty; av_q <= cidx_q;
      end
    end
    cidx_q <= idx_q;
  end

  always_comb begin
    spread_w = '0;
    sum_w = '0;
    if (bp_q != '0 && ap_q != '0) begin
      spread_w = {1'b0, ap_q} - {1'b0, bp_q};
      sum_w = {1'b0, ap_q} + {1'b0, bp_q};
    end
    fresh_sat = (32'(fresh_q) > 31) ? 5'd31 : 5'(fresh_q);
  end

  assign out_valid_o = (state_q == mvbbo_pkg::StOut);
  assign out_item_o = {bp_q, bq_q, mvbbo_pkg::VenueW'(bv_q), ap_q, aq_q,
                       mvbbo_pkg::VenueW'(av_q), spread_w, sum_w[VW:1], fresh_sat};

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("input taken while result pending");
  a_scan_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (scanning && last) |=> state_q == mvbbo_pkg::StFinish)
    else $error("scan did not end");
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> scanning && idx_q == '0) else $error("scan did not start");
  a_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != mvbbo_pkg::StIdle) |-> 32'(fresh_q) <= NUM_VENUES)
    else $error("fresh count overflow");

endmodule

>>> hdl/mvbbo_cell.sv
module mvbbo_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mvbbo_pkg::cell_ctrl_t ctrl_i,
  input  mvbbo_pkg::entry_t   entry_i,
  output mvbbo_pkg::entry_t   entry_o
);

  logic present_q, present_d, stale_q, stale_d;
  logic [mvbbo_pkg::ValW-1:0] bid_px_q, bid_qty_q, ask_px_q, ask_qty_q, last_update_q;
  logic [mvbbo_pkg::ValW-1:0] age;

  // Only the head cell sees apply; the event is applied as the entry enters it.
  always_comb begin
    present_d = entry_i.present;
    stale_d = entry_i.stale;
    age = ctrl_i.now - entry_i.last_update;
    if (ctrl_i.apply) begin
      case (ctrl_i.mode)
        mvbbo_pkg::ModeUpdate: if (ctrl_i.hit) begin
          present_d = 1'b1;
          stale_d = 1'b0;
        end
        mvbbo_pkg::ModeStale: if (ctrl_i.hit && entry_i.present) stale_d = 1'b1;
        mvbbo_pkg::ModeRemove: if (ctrl_i.hit) begin
          present_d = 1'b0;
          stale_d = 1'b0;
        end
        mvbbo_pkg::ModeCheck: begin
          if (entry_i.present && ctrl_i.now >= entry_i.last_update &&
              age > {{(mvbbo_pkg::ValW-mvbbo_pkg::AgeW){1'b0}}, ctrl_i.max_age})
            stale_d = 1'b1;
        end
        mvbbo_pkg::ModeClear: begin
          present_d = 1'b0;
          stale_d = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= 1'b0;
      stale_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      present_q <= present_d;
      stale_q <= stale_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      if (ctrl_i.apply && ctrl_i.hit && ctrl_i.mode == mvbbo_pkg::ModeUpdate) begin
        bid_px_q <= ctrl_i.bid_px;
        bid_qty_q <= ctrl_i.bid_qty;
        ask_px_q <= ctrl_i.ask_px;
        ask_qty_q <= ctrl_i.ask_qty;
        last_update_q <= ctrl_i.now;
      end else begin
        bid_px_q <= entry_i.bid_px;
        bid_qty_q <= entry_i.bid_qty;
        ask_px_q <= entry_i.ask_px;
        ask_qty_q <= entry_i.ask_qty;
        last_update_q <= entry_i.last_update;
      end
    end
  end

  assign entry_o = {present_q, stale_q, bid_px_q, bid_qty_q, ask_px_q, ask_qty_q,
                    last_update_q};

endmodule
